// ===== rtl/core/stable_min_priority_queue_defines.svh =====
// Assertion macros used by the priority queue checker.
`ifndef STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define SMPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("priority queue assertion failed");

// Concurrent assertion that also holds during reset.
`define SMPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("priority queue reset assertion failed");

`endif

// ===== rtl/core/smpq_pkg.sv =====
// Types and constants of the stable minimum priority queue.
`default_nettype none
package smpq_pkg;

   localparam int CAPACITY    = 16;
   localparam int DATA_W      = 8;
   localparam int PRIO_W      = 8;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int REQ_TDATA_W = ((DATA_W + PRIO_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - DATA_W - COUNT_W;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [DATA_W-1:0] value;
      logic [PRIO_W-1:0] prio;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/core/smpq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts toward either neighbor.
`default_nettype none
module smpq_cell import smpq_pkg::*; (
   input  wire logic      clock,
   input  wire ctrl_type  ctrl,
   input  wire logic      occupied,
   input  wire logic      left_stays,
   input  wire entry_type left_entry,
   input  wire entry_type right_entry,
   output logic           stays,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // An entry stays in place when it is held and not ranked after the new item.
   assign stays = occupied && (entry_ff.prio <= ctrl.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!stays) begin
            if (left_stays) begin
               entry_in.value = ctrl.value;
               entry_in.prio  = ctrl.prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/stable_min_priority_queue.sv =====
// Top level of the stable minimum priority queue built as a chain of cells.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one insert or remove per cycle while the response is not stalled; every cell updates in that cycle.
// A stalled response holds the request side until it is taken.
// Reset clears the entry count and the response valid; entry contents are not cleared.
`default_nettype none
module stable_min_priority_queue import smpq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // item_value, priority_req
   input  wire logic                   req_tuser,  // command
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // removed_value, entry_count, zero pad
   output logic [1:0]                  rsp_tuser   // status
);

   logic               accept;
   logic               full;
   logic               empty;
   cmd_type            cmd;
   ctrl_type           ctrl;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff;
   logic [DATA_W-1:0]  rsp_value_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   entry_type          cell_entry [CAPACITY];
   logic               cell_stays [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign full       = (count_ff == COUNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   assign ctrl.insert = accept && (cmd == CMD_INSERT) && !full;
   assign ctrl.remove = accept && (cmd == CMD_REMOVE) && !empty;
   assign ctrl.value  = req_tdata[DATA_W-1:0];
   assign ctrl.prio   = req_tdata[DATA_W+PRIO_W-1:DATA_W];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_stays;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_stays = 1'b1;
         assign left_entry = '0;
      end else begin : g_inner
         assign left_stays = cell_stays[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > COUNT_W'(i)),
         .left_stays  (left_stays),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .stays       (cell_stays[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = STATUS_OK;
         case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  count_in     = count_ff - COUNT_W'(1);
                  rsp_value_in = cell_entry[0].value;
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/core/smpq_checker.sv =====
// Port-level checker for the stable minimum priority queue and its bind.
`default_nettype none
`include "stable_min_priority_queue_defines.svh"
module smpq_checker import smpq_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]             rsp_tuser
);

   logic [COUNT_W-1:0]       rsp_count;
   logic [DATA_W-1:0]        rsp_value;
   logic [RSP_TDATA_W+1:0]   rsp_word;
   logic                     rsp_stall;
   logic                     rsp_empty_seen;
   logic                     rsp_full_seen;
   logic                     rsp_count_full;

   assign rsp_count      = rsp_tdata[DATA_W+COUNT_W-1:DATA_W];
   assign rsp_value      = rsp_tdata[DATA_W-1:0];
   assign rsp_word       = {rsp_tuser, rsp_tdata};
   assign rsp_stall      = rsp_tvalid && !rsp_tready;
   assign rsp_empty_seen = rsp_tvalid && (rsp_tuser == STATUS_EMPTY);
   assign rsp_full_seen  = rsp_tvalid && (rsp_tuser == STATUS_FULL);
   assign rsp_count_full = (rsp_count == COUNT_W'(CAPACITY));

   `SMPQ_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)
   `SMPQ_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word))
   `SMPQ_ASSERT(a_ready_when_free, clock, reset, !rsp_tvalid |-> req_tready)
   `SMPQ_ASSERT(a_empty_report, clock, reset, rsp_empty_seen |-> rsp_count == '0 && rsp_value == '0)
   `SMPQ_ASSERT(a_full_report, clock, reset, rsp_full_seen |-> rsp_count_full && rsp_value == '0)

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);
`default_nettype wire
